// ===== rtl/wasc_pkg.sv =====
// Shared constants, types and the CRC-32 byte step for the weight artifact stream checker.
package wasc_pkg;

  localparam int MAX_ID_BYTES = 8;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [7:0] MAGIC_BYTES [8] = '{
    8'h56, 8'h4F, 8'h50, 8'h57, 8'h47, 8'h54, 8'h00, 8'h00
  };

  // configuration register indexes
  localparam logic [3:0] REG_FORMAT_VERSION = 4'd0;
  localparam logic [3:0] REG_BIT_ORDER      = 4'd1;
  localparam logic [3:0] REG_SCORE_UNIT     = 4'd2;
  localparam logic [3:0] REG_PHASE_COUNT    = 4'd3;
  localparam logic [3:0] REG_PATTERN_COUNT  = 4'd4;
  localparam logic [3:0] REG_WEIGHT_COUNT   = 4'd5;
  localparam logic [3:0] REG_SET_ID_LENGTH  = 4'd6;
  localparam logic [3:0] REG_SET_ID_BYTES   = 4'd7;

  // status codes
  localparam logic [3:0] ST_OK           = 4'd0;
  localparam logic [3:0] ST_TRUNCATED    = 4'd1;
  localparam logic [3:0] ST_BAD_MAGIC    = 4'd2;
  localparam logic [3:0] ST_VERSION      = 4'd3;
  localparam logic [3:0] ST_BIT_ORDER    = 4'd4;
  localparam logic [3:0] ST_UNIT         = 4'd5;
  localparam logic [3:0] ST_SCALE        = 4'd6;
  localparam logic [3:0] ST_PHASES       = 4'd7;
  localparam logic [3:0] ST_PATTERNS     = 4'd8;
  localparam logic [3:0] ST_WEIGHT_COUNT = 4'd9;
  localparam logic [3:0] ST_ID_MISMATCH  = 4'd10;
  localparam logic [3:0] ST_CHECKSUM     = 4'd11;

  typedef struct packed {
    logic               is_status;
    logic signed [31:0] weight_value;
    logic [31:0]        weight_index;
    logic [3:0]         status_code;
    logic               end_of_artifact;
  } result_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

// ===== rtl/weight_artifact_stream_checker_core.sv =====
// Top level: byte-serial weight artifact parser with header checks and CRC-32.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one artifact byte per item plus
//   in_final_byte on the last byte. Result channel (out_valid/out_ready)
//   carries weight items (out_is_status = 0) as each 4-byte weight completes,
//   and one status item (out_is_status = 1, out_end_of_artifact = 1) on the
//   final byte. A byte that completes a weight and ends the artifact yields
//   the weight item first, then the status item.
//   Configuration: write cfg_wdata to register cfg_index while cfg_wr_en is
//   high; only while the block is idle. Indexes above 7 are ignored.
// Timing:
//   Each accepted byte is parsed in the cycle it is accepted; its results
//   enter a 4-entry result queue and are presented on the output from there.
//   One byte per cycle is accepted as long as the receiver keeps up; a byte
//   giving two results puts both in the queue. in_ready drops when fewer
//   than two queue entries are free, so a stalled receiver backs up into the
//   input and nothing is lost.
// Reset: rst_n (synchronous, active low) empties the queue, returns the
//   parser to the magic section and loads the configuration defaults.
module weight_artifact_stream_checker_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_final_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_is_status,
  output logic signed [31:0] out_weight_value,
  output logic [31:0]        out_weight_index,
  output logic [3:0]         out_status_code,
  output logic               out_end_of_artifact,
  input  logic               cfg_wr_en,
  input  logic [3:0]         cfg_index,
  input  logic [63:0]        cfg_wdata
);
  import wasc_pkg::*;

  typedef enum logic [2:0] {
    SEC_MAGIC    = 3'd0,
    SEC_HEADER   = 3'd1,
    SEC_ID       = 3'd2,
    SEC_WEIGHTS  = 3'd3,
    SEC_CHECKSUM = 3'd4,
    SEC_DRAIN    = 3'd5
  } sec_t;

  // configuration
  logic [15:0]     exp_version_r, exp_bit_order_r, exp_unit_r, exp_phases_r, exp_patterns_r;
  logic [31:0]     exp_wcount_r;
  logic [3:0]      set_id_len_r;
  logic [7:0][7:0] set_id_r;

  // parser state
  sec_t        sec_r, sec_nxt;
  logic [4:0]  off_r, off_nxt;
  logic [5:0]  tsc_r, tsc_nxt;
  logic [31:0] fs_r, fs_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [15:0] hid_len_r, hid_len_nxt;
  logic [31:0] hwc_r, hwc_nxt;
  logic [31:0] ws_r, ws_nxt;
  logic [3:0]  ferr_r, ferr_nxt;
  logic [15:0] ido_r, ido_nxt;

  // result queue
  result_t             fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0]  count_r;

  logic        in_acc, out_acc;
  result_t     res0, res1;
  logic [1:0]  nres;
  logic        fail_en, sum_done, bad;
  logic [3:0]  fail_code, code;
  logic [15:0] hv;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign in_ready = count_r < FIFO_CW'(FIFO_DEPTH - 1);

  always_comb begin
    sec_nxt     = sec_r;
    off_nxt     = off_r;
    tsc_nxt     = tsc_r;
    fs_nxt      = fs_r;
    crc_nxt     = crc_r;
    hid_len_nxt = hid_len_r;
    hwc_nxt     = hwc_r;
    ws_nxt      = ws_r;
    ferr_nxt    = ferr_r;
    ido_nxt     = ido_r;
    res0        = '0;
    res1        = '0;
    nres        = 2'd0;
    fail_en     = 1'b0;
    fail_code   = ST_OK;
    sum_done    = 1'b0;
    bad         = 1'b1;
    code        = ST_OK;
    hv          = '0;
    if (in_acc) begin
      if (tsc_r < 6'd32) begin
        tsc_nxt = tsc_r + 6'd1;
      end
      if (sec_r == SEC_MAGIC || sec_r == SEC_HEADER || sec_r == SEC_ID ||
          sec_r == SEC_WEIGHTS) begin
        crc_nxt = crc32_byte(crc_r, in_data_byte);
      end
      case (sec_r)
        SEC_MAGIC: begin
          if (in_data_byte != MAGIC_BYTES[off_r[2:0]]) begin
            fail_en   = 1'b1;
            fail_code = ST_BAD_MAGIC;
          end else if (off_r >= 5'd7) begin
            sec_nxt = SEC_HEADER;
            off_nxt = '0;
          end else begin
            off_nxt = off_r + 5'd1;
          end
        end
        SEC_HEADER: begin
          fs_nxt  = {in_data_byte, fs_r[31:8]};
          hv      = fs_nxt[31:16];
          off_nxt = off_r + 5'd1;
          case (off_r)
            5'd1: if (hv != exp_version_r) begin
              fail_en = 1'b1; fail_code = ST_VERSION;
            end
            5'd3: if (hv != exp_bit_order_r) begin
              fail_en = 1'b1; fail_code = ST_BIT_ORDER;
            end
            5'd5: if (hv != exp_unit_r) begin
              fail_en = 1'b1; fail_code = ST_UNIT;
            end
            5'd7: if (hv != 16'd1) begin
              fail_en = 1'b1; fail_code = ST_SCALE;
            end
            5'd9: if (hv != exp_phases_r) begin
              fail_en = 1'b1; fail_code = ST_PHASES;
            end
            5'd11: if (hv != exp_patterns_r) begin
              fail_en = 1'b1; fail_code = ST_PATTERNS;
            end
            5'd13: hid_len_nxt = hv;
            5'd15: if (hv != 16'd0) begin
              fail_en = 1'b1; fail_code = ST_TRUNCATED;
            end
            5'd19: begin
              if (fs_nxt != exp_wcount_r) begin
                fail_en = 1'b1; fail_code = ST_WEIGHT_COUNT;
              end else begin
                hwc_nxt = fs_nxt;
                fs_nxt  = '0;
                ido_nxt = '0;
                off_nxt = '0;
                if (hid_len_r == 16'd0) begin
                  if (set_id_len_r != 4'd0) begin
                    fail_en = 1'b1; fail_code = ST_ID_MISMATCH;
                  end else begin
                    sec_nxt = (hwc_nxt != 32'd0) ? SEC_WEIGHTS : SEC_CHECKSUM;
                  end
                end else begin
                  sec_nxt = SEC_ID;
                end
              end
            end
            default: ;
          endcase
        end
        SEC_ID: begin
          if (ido_r < 16'(MAX_ID_BYTES) && ido_r < {12'd0, set_id_len_r}) begin
            bad = set_id_r[ido_r[2:0]] != in_data_byte;
          end
          if (bad) begin
            fs_nxt[0] = 1'b1;
          end
          ido_nxt = ido_r + 16'd1;
          if (ido_nxt == hid_len_r) begin
            if (fs_nxt[0] || {12'd0, set_id_len_r} != hid_len_r) begin
              fail_en = 1'b1; fail_code = ST_ID_MISMATCH;
            end else begin
              sec_nxt = (hwc_r != 32'd0) ? SEC_WEIGHTS : SEC_CHECKSUM;
              off_nxt = '0;
            end
          end
        end
        SEC_WEIGHTS: begin
          fs_nxt = {in_data_byte, fs_r[31:8]};
          if (off_r >= 5'd3) begin
            res0.weight_value = fs_nxt;
            res0.weight_index = ws_r;
            nres    = 2'd1;
            ws_nxt  = ws_r + 32'd1;
            off_nxt = '0;
            if (ws_nxt == hwc_r) begin
              sec_nxt = SEC_CHECKSUM;
            end
          end else begin
            off_nxt = off_r + 5'd1;
          end
        end
        SEC_CHECKSUM: begin
          fs_nxt = {in_data_byte, fs_r[31:8]};
          if (off_r >= 5'd3) begin
            sum_done = 1'b1;
            if (!in_final_byte) begin
              fail_en = 1'b1; fail_code = ST_TRUNCATED;
            end
          end else begin
            off_nxt = off_r + 5'd1;
          end
        end
        default: ;
      endcase
      if (fail_en) begin
        if (ferr_r == ST_OK) begin
          ferr_nxt = fail_code;
        end
        sec_nxt = SEC_DRAIN;
      end
      if (in_final_byte) begin
        if (tsc_nxt < 6'd32) begin
          code = ST_TRUNCATED;
        end else if (ferr_nxt != ST_OK) begin
          code = ferr_nxt;
        end else if (sum_done) begin
          code = (fs_nxt == ~crc_nxt) ? ST_OK : ST_CHECKSUM;
        end else begin
          code = ST_TRUNCATED;
        end
        if (nres == 2'd1) begin
          res1.is_status       = 1'b1;
          res1.status_code     = code;
          res1.end_of_artifact = 1'b1;
          nres = 2'd2;
        end else begin
          res0.is_status       = 1'b1;
          res0.status_code     = code;
          res0.end_of_artifact = 1'b1;
          nres = 2'd1;
        end
        sec_nxt     = SEC_MAGIC;
        off_nxt     = '0;
        tsc_nxt     = '0;
        fs_nxt      = '0;
        crc_nxt     = CRC_INIT;
        hid_len_nxt = '0;
        hwc_nxt     = '0;
        ws_nxt      = '0;
        ferr_nxt    = ST_OK;
        ido_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_version_r   <= 16'd1;
      exp_bit_order_r <= '0;
      exp_unit_r      <= '0;
      exp_phases_r    <= 16'd1;
      exp_patterns_r  <= '0;
      exp_wcount_r    <= '0;
      set_id_len_r    <= '0;
      set_id_r        <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FORMAT_VERSION: exp_version_r   <= cfg_wdata[15:0];
        REG_BIT_ORDER:      exp_bit_order_r <= cfg_wdata[15:0];
        REG_SCORE_UNIT:     exp_unit_r      <= cfg_wdata[15:0];
        REG_PHASE_COUNT:    exp_phases_r    <= cfg_wdata[15:0];
        REG_PATTERN_COUNT:  exp_patterns_r  <= cfg_wdata[15:0];
        REG_WEIGHT_COUNT:   exp_wcount_r    <= cfg_wdata[31:0];
        REG_SET_ID_LENGTH:  set_id_len_r    <= cfg_wdata[3:0];
        REG_SET_ID_BYTES:   set_id_r        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r     <= SEC_MAGIC;
      off_r     <= '0;
      tsc_r     <= '0;
      fs_r      <= '0;
      crc_r     <= CRC_INIT;
      hid_len_r <= '0;
      hwc_r     <= '0;
      ws_r      <= '0;
      ferr_r    <= ST_OK;
      ido_r     <= '0;
    end else begin
      sec_r     <= sec_nxt;
      off_r     <= off_nxt;
      tsc_r     <= tsc_nxt;
      fs_r      <= fs_nxt;
      crc_r     <= crc_nxt;
      hid_len_r <= hid_len_nxt;
      hwc_r     <= hwc_nxt;
      ws_r      <= ws_nxt;
      ferr_r    <= ferr_nxt;
      ido_r     <= ido_nxt;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (nres != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (nres == 2'd2) begin
      fifo_r[wr_ptr_r + FIFO_AW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + FIFO_AW'(nres);
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      count_r <= count_r + FIFO_CW'(nres) - FIFO_CW'(out_acc);
    end
  end

  assign out_valid           = count_r != '0;
  assign out_is_status       = fifo_r[rd_ptr_r].is_status;
  assign out_weight_value    = fifo_r[rd_ptr_r].weight_value;
  assign out_weight_index    = fifo_r[rd_ptr_r].weight_index;
  assign out_status_code     = fifo_r[rd_ptr_r].status_code;
  assign out_end_of_artifact = fifo_r[rd_ptr_r].end_of_artifact;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_final_byte) |=> (sec_r == SEC_MAGIC && crc_r == CRC_INIT && tsc_r == '0))
    else $error("parser not restarted after final byte");

  a_weight_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_status) |-> (out_status_code == ST_OK && !out_end_of_artifact))
    else $error("weight item carries status fields");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_status) |-> (out_status_code <= ST_CHECKSUM && out_end_of_artifact))
    else $error("bad status item");

  a_small_count: assert property (@(posedge clk) disable iff (!rst_n)
    tsc_r <= 6'd32)
    else $error("byte count past saturation");

endmodule
